// ===== hw/rtl/env_comp_pkg.sv =====
// shared types and constants for the environmental sensor compensation pipeline
package env_comp_pkg;

    localparam int ADDR_W             = 6;
    localparam int DATA_W             = 64;
    localparam int FINE_LAT           = 4;
    localparam int TEMP_LAT           = 5;
    localparam int HUM_LAT            = 15;
    localparam int PIPE_LAT           = 52;
    localparam int DIV_STAGES         = 32;
    localparam int DIV_BITS_PER_STAGE = 2;

    localparam logic signed [32:0] PRESS_OFFSET_FINE = 33'sd128000;
    localparam logic [11:0]        PRESS_SCALE       = 12'd3125;
    localparam logic [20:0]        PRESS_RAW_BIAS    = 21'd1048576;
    localparam logic [31:0]        HUM_OFFSET_FINE   = 32'd76800;
    localparam logic signed [31:0] HUM_CLAMP_MAX     = 32'sd419430400;
    localparam logic [31:0]        HUM_ROUND         = 32'd16384;
    localparam logic [31:0]        HUM_BIAS          = 32'd2097152;
    localparam logic [16:0]        HUM_OUT_MAX       = 17'd102400;

    typedef enum logic [2:0] {
        REG_TEMP_CAL   = 3'd0,
        REG_PRESS_LO   = 3'd1,
        REG_PRESS_HI   = 3'd2,
        REG_PRESS_LAST = 3'd3,
        REG_HUM_CAL    = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [47:0] temp;
        logic [63:0] press_lo;
        logic [63:0] press_hi;
        logic [15:0] press_last;
        logic [63:0] hum;
    } cal_t;

endpackage

// ===== hw/rtl/env_comp_temp.sv =====
// temperature path: fine temperature and centi-degree output
module env_comp_temp (
    input  logic                aclk,
    input  logic                en,
    input  logic [19:0]         raw_temperature,
    input  env_comp_pkg::cal_t  cal,
    output logic [31:0]         fine,
    output logic [23:0]         temp
);
    import env_comp_pkg::*;

    logic [15:0]        t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic signed [17:0] a;
    logic signed [16:0] b;
    logic signed [33:0] av_next, av_reg;
    logic signed [33:0] bb_next, bb_reg;
    logic [31:0]        v1_next, v1_reg, v1b_reg;
    logic signed [19:0] bq_next, bq_reg;
    logic signed [35:0] c_next, c_reg;
    logic [31:0]        fine_next, fine_reg;
    logic [31:0]        tsum;
    logic [23:0]        temp_next, temp_reg;

    assign t1 = cal.temp[15:0];
    assign t2 = $signed(cal.temp[31:16]);
    assign t3 = $signed(cal.temp[47:32]);

    always_comb begin
        a         = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
        b         = $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, t1});
        av_next   = a * t2;
        bb_next   = b * b;
        v1_next   = 32'($signed(av_reg[31:0]) >>> 11);
        bq_next   = $signed(bb_reg[31:12]);
        c_next    = bq_reg * t3;
        fine_next = v1b_reg + 32'($signed(c_reg[31:0]) >>> 14);
        tsum      = {fine_reg[29:0], 2'b00} + fine_reg + 32'd128;
        temp_next = tsum[31:8];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            av_reg   <= av_next;
            bb_reg   <= bb_next;
            v1_reg   <= v1_next;
            bq_reg   <= bq_next;
            c_reg    <= c_next;
            v1b_reg  <= v1_reg;
            fine_reg <= fine_next;
            temp_reg <= temp_next;
        end
    end

    assign fine = fine_reg;
    assign temp = temp_reg;

endmodule

// ===== hw/rtl/env_comp_press_pre.sv =====
// pressure front end: builds the 64-bit dividend and the divisor
module env_comp_press_pre (
    input  logic               aclk,
    input  logic               en,
    input  logic [31:0]        fine,
    input  logic [19:0]        raw_pressure,
    input  env_comp_pkg::cal_t cal,
    output logic [63:0]        num,
    output logic [30:0]        div
);
    import env_comp_pkg::*;

    logic [15:0]        p1;
    logic signed [15:0] p2, p3, p4, p5, p6;
    logic signed [32:0] d_next, d_reg;
    logic [20:0]        pr_next, pr1_reg, pr2_reg, pr3_reg, pr4_reg;
    logic signed [65:0] dd_full;
    logic [63:0]        dd_reg;
    logic signed [48:0] dp5_next, dp5_reg, dp5b_reg;
    logic signed [48:0] dp2_next, dp2_reg, dp2b_reg, dp2c_reg;
    logic signed [48:0] l6_next, l6_reg, l3_next, l3_reg;
    logic signed [48:0] h6_full, h3_full;
    logic [31:0]        h6_reg, h3_reg;
    logic [63:0]        w2_next, w2_reg, t3v_next, t3v_reg;
    logic [63:0]        e_next, e_reg, nn_next, nn_reg;
    logic [47:0]        el_next, el_reg;
    logic [31:0]        eh_next, eh_reg, nh_next, nh_reg;
    logic [43:0]        nl_next, nl_reg;
    logic [63:0]        es;
    logic [30:0]        div_next, div_reg;
    logic [63:0]        num_next, num_reg;

    assign p1 = cal.press_lo[15:0];
    assign p2 = $signed(cal.press_lo[31:16]);
    assign p3 = $signed(cal.press_lo[47:32]);
    assign p4 = $signed(cal.press_lo[63:48]);
    assign p5 = $signed(cal.press_hi[15:0]);
    assign p6 = $signed(cal.press_hi[31:16]);

    always_comb begin
        d_next   = $signed({fine[31], fine}) - PRESS_OFFSET_FINE;
        pr_next  = PRESS_RAW_BIAS - {1'b0, raw_pressure};
        dd_full  = d_reg * d_reg;
        dp5_next = d_reg * p5;
        dp2_next = d_reg * p2;
        // 64-bit wrap products split on the 32-bit boundary of dd
        l6_next  = $signed({1'b0, dd_reg[31:0]}) * p6;
        h6_full  = $signed({1'b0, dd_reg[63:32]}) * p6;
        l3_next  = $signed({1'b0, dd_reg[31:0]}) * p3;
        h3_full  = $signed({1'b0, dd_reg[63:32]}) * p3;
        w2_next  = {{15{l6_reg[48]}}, l6_reg} + {h6_reg, 32'd0}
                 + ({{15{dp5b_reg[48]}}, dp5b_reg} << 17)
                 + ({{48{p4[15]}}, p4} << 35);
        t3v_next = {{15{l3_reg[48]}}, l3_reg} + {h3_reg, 32'd0};
        e_next   = 64'($signed(t3v_reg) >>> 8)
                 + ({{15{dp2c_reg[48]}}, dp2c_reg} << 12)
                 + 64'h0000_8000_0000_0000;
        nn_next  = {12'd0, pr4_reg, 31'd0} - w2_reg;
        el_next  = e_reg[31:0] * p1;
        eh_next  = e_reg[63:32] * {16'd0, p1};
        nl_next  = nn_reg[31:0] * PRESS_SCALE;
        nh_next  = nn_reg[63:32] * {20'd0, PRESS_SCALE};
        es       = {16'd0, el_reg} + {eh_reg, 32'd0};
        div_next = es[63:33];
        num_next = {20'd0, nl_reg} + {nh_reg, 32'd0};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg    <= d_next;
            pr1_reg  <= pr_next;
            dd_reg   <= dd_full[63:0];
            dp5_reg  <= dp5_next;
            dp2_reg  <= dp2_next;
            pr2_reg  <= pr1_reg;
            l6_reg   <= l6_next;
            h6_reg   <= h6_full[31:0];
            l3_reg   <= l3_next;
            h3_reg   <= h3_full[31:0];
            dp5b_reg <= dp5_reg;
            dp2b_reg <= dp2_reg;
            pr3_reg  <= pr2_reg;
            w2_reg   <= w2_next;
            t3v_reg  <= t3v_next;
            dp2c_reg <= dp2b_reg;
            pr4_reg  <= pr3_reg;
            e_reg    <= e_next;
            nn_reg   <= nn_next;
            el_reg   <= el_next;
            eh_reg   <= eh_next;
            nl_reg   <= nl_next;
            nh_reg   <= nh_next;
            div_reg  <= div_next;
            num_reg  <= num_next;
        end
    end

    assign num = num_reg;
    assign div = div_reg;

endmodule

// ===== hw/rtl/env_comp_div.sv =====
// pipelined signed 64 by 31 bit divider, restoring, two quotient bits per stage
module env_comp_div (
    input  logic        aclk,
    input  logic        en,
    input  logic [63:0] num,
    input  logic [30:0] div,
    output logic [63:0] quo,
    output logic        invalid
);
    import env_comp_pkg::*;

    logic [63:0] nq_next  [0:DIV_STAGES];
    logic [63:0] nq_reg   [0:DIV_STAGES];
    logic [30:0] rem_next [0:DIV_STAGES];
    logic [30:0] rem_reg  [0:DIV_STAGES];
    logic [30:0] dv_next;
    logic [30:0] dv_reg   [0:DIV_STAGES];
    logic        sg_reg   [0:DIV_STAGES];
    logic        inv_reg  [0:DIV_STAGES];
    logic [30:0] rem_w;
    logic [63:0] nq_w;
    logic [31:0] tr;
    logic        ge;
    logic [63:0] quo_next, quo_reg;
    logic        inv_out_reg;

    always_comb begin
        // magnitudes; a zero divisor is flagged and its quotient discarded
        nq_next[0]  = num[63] ? (~num + 64'd1) : num;
        dv_next     = div[30] ? (~div + 31'd1) : div;
        rem_next[0] = '0;
        rem_w       = '0;
        nq_w        = '0;
        tr          = '0;
        ge          = 1'b0;
        for (int s = 1; s <= DIV_STAGES; s++) begin
            rem_w = rem_reg[s-1];
            nq_w  = nq_reg[s-1];
            for (int k = 0; k < DIV_BITS_PER_STAGE; k++) begin
                tr    = {rem_w, nq_w[63]};
                ge    = (tr >= {1'b0, dv_reg[s-1]});
                rem_w = ge ? 31'(tr - {1'b0, dv_reg[s-1]}) : tr[30:0];
                nq_w  = {nq_w[62:0], ge};
            end
            rem_next[s] = rem_w;
            nq_next[s]  = nq_w;
        end
        if (inv_reg[DIV_STAGES]) begin
            quo_next = '0;
        end else if (sg_reg[DIV_STAGES]) begin
            quo_next = ~nq_reg[DIV_STAGES] + 64'd1;
        end else begin
            quo_next = nq_reg[DIV_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nq_reg[0]  <= nq_next[0];
            rem_reg[0] <= rem_next[0];
            dv_reg[0]  <= dv_next;
            sg_reg[0]  <= num[63] ^ div[30];
            inv_reg[0] <= (div == '0);
            for (int s = 1; s <= DIV_STAGES; s++) begin
                nq_reg[s]  <= nq_next[s];
                rem_reg[s] <= rem_next[s];
                dv_reg[s]  <= dv_reg[s-1];
                sg_reg[s]  <= sg_reg[s-1];
                inv_reg[s] <= inv_reg[s-1];
            end
            quo_reg     <= quo_next;
            inv_out_reg <= inv_reg[DIV_STAGES];
        end
    end

    assign quo     = quo_reg;
    assign invalid = inv_out_reg;

endmodule

// ===== hw/rtl/env_comp_press_post.sv =====
// pressure back end: second-order correction, offset and saturation
module env_comp_press_post (
    input  logic               aclk,
    input  logic               en,
    input  logic [63:0]        quo,
    input  logic               invalid,
    input  env_comp_pkg::cal_t cal,
    output logic [31:0]        press,
    output logic               press_invalid
);
    import env_comp_pkg::*;

    logic signed [15:0] p7, p8, p9;
    logic [63:0]        q64;
    logic signed [48:0] pa_next, pa_reg, pc_next, pc_reg;
    logic signed [34:0] pb_full;
    logic signed [47:0] pd_full;
    logic [31:0]        pb_reg, pd_reg;
    logic [63:0]        p1_reg, p2_reg, p3_reg, p4_reg;
    logic [63:0]        q1_reg, q2_reg;
    logic [63:0]        r_next, r_reg;
    logic [63:0]        w2s, w2b_next, w2b_reg, w2b3_reg, w2b4_reg;
    logic [63:0]        ll_next, ll_reg;
    logic [31:0]        cr_next, cr_reg;
    logic [31:0]        cr_a, cr_b;
    logic [63:0]        w1b_next, w1b_reg;
    logic [63:0]        s_next, s_reg;
    logic [63:0]        pf_next, pf_reg;
    logic [31:0]        press_next, press_reg;
    logic               inv1_reg, inv2_reg, inv3_reg, inv4_reg, inv5_reg, inv6_reg, inv7_reg;

    assign p7 = $signed(cal.press_hi[47:32]);
    assign p8 = $signed(cal.press_hi[63:48]);
    assign p9 = $signed(cal.press_last);

    always_comb begin
        q64      = 64'($signed(quo) >>> 13);
        pa_next  = $signed({1'b0, q64[31:0]}) * p9;
        pb_full  = $signed(q64[50:32]) * p9;
        pc_next  = $signed({1'b0, quo[31:0]}) * p8;
        pd_full  = $signed(quo[63:32]) * p8;
        r_next   = {{15{pa_reg[48]}}, pa_reg} + {pb_reg, 32'd0};
        w2s      = {{15{pc_reg[48]}}, pc_reg} + {pd_reg, 32'd0};
        w2b_next = 64'($signed(w2s) >>> 19);
        // full 64-bit wrap product from three 32x32 partials
        ll_next  = r_reg[31:0] * q2_reg[31:0];
        cr_a     = r_reg[31:0] * q2_reg[63:32];
        cr_b     = r_reg[63:32] * q2_reg[31:0];
        cr_next  = cr_a + cr_b;
        w1b_next = 64'($signed(ll_reg + {cr_reg, 32'd0}) >>> 25);
        s_next   = p4_reg + w1b_reg + w2b4_reg;
        pf_next  = 64'($signed(s_reg) >>> 8) + ({{48{p7[15]}}, p7} << 4);
        if (inv6_reg || pf_reg[63]) begin
            press_next = '0;
        end else if (pf_reg[63:32] != '0) begin
            press_next = '1;
        end else begin
            press_next = pf_reg[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pa_reg    <= pa_next;
            pb_reg    <= pb_full[31:0];
            pc_reg    <= pc_next;
            pd_reg    <= pd_full[31:0];
            p1_reg    <= quo;
            q1_reg    <= q64;
            inv1_reg  <= invalid;
            r_reg     <= r_next;
            w2b_reg   <= w2b_next;
            p2_reg    <= p1_reg;
            q2_reg    <= q1_reg;
            inv2_reg  <= inv1_reg;
            ll_reg    <= ll_next;
            cr_reg    <= cr_next;
            w2b3_reg  <= w2b_reg;
            p3_reg    <= p2_reg;
            inv3_reg  <= inv2_reg;
            w1b_reg   <= w1b_next;
            w2b4_reg  <= w2b3_reg;
            p4_reg    <= p3_reg;
            inv4_reg  <= inv3_reg;
            s_reg     <= s_next;
            inv5_reg  <= inv4_reg;
            pf_reg    <= pf_next;
            inv6_reg  <= inv5_reg;
            press_reg <= press_next;
            inv7_reg  <= inv6_reg;
        end
    end

    assign press         = press_reg;
    assign press_invalid = inv7_reg;

endmodule

// ===== hw/rtl/env_comp_hum.sv =====
// humidity path on a wrapping 32-bit datapath, clamped to 0..100 %RH
module env_comp_hum (
    input  logic               aclk,
    input  logic               en,
    input  logic [31:0]        fine,
    input  logic [15:0]        raw_humidity,
    input  env_comp_pkg::cal_t cal,
    output logic [16:0]        hum
);
    import env_comp_pkg::*;

    logic [31:0] h1, h2, h3, h4, h5, h6;
    logic [31:0] x_next, x_reg;
    logic [15:0] adc1_reg, adc2_reg;
    logic [31:0] m5_next, m5_reg, m6_next, m6_reg, m3_next, m3_reg;
    logic [31:0] hv_next, hv3_reg, hv4_reg, hv5_reg, hv6_reg, hv7_reg;
    logic [31:0] g1_next, g1_reg, g2_next, g2_reg;
    logic [31:0] gp_next, gp_reg, gb_next, gb_reg, gm_next, gm_reg, gc_next, gc_reg;
    logic [31:0] x2_next, x2_reg, x2b_reg, x2c_reg;
    logic [31:0] y, yy_next, yy_reg, zh_next, zh_reg;
    logic [31:0] x3;
    logic [31:0] hs;
    logic [16:0] hum_next, hum_reg;

    assign h1 = {24'd0, cal.hum[7:0]};
    assign h2 = {{16{cal.hum[23]}}, cal.hum[23:8]};
    assign h3 = {24'd0, cal.hum[31:24]};
    assign h4 = {{20{cal.hum[43]}}, cal.hum[43:32]};
    assign h5 = {{20{cal.hum[55]}}, cal.hum[55:44]};
    assign h6 = {{24{cal.hum[63]}}, cal.hum[63:56]};

    always_comb begin
        x_next  = fine - HUM_OFFSET_FINE;
        m5_next = h5 * x_reg;
        m6_next = x_reg * h6;
        m3_next = x_reg * h3;
        hv_next = 32'($signed({2'b00, adc2_reg, 14'd0} - {h4[11:0], 20'd0} - m5_reg
                  + HUM_ROUND) >>> 15);
        g1_next = 32'($signed(m6_reg) >>> 10);
        g2_next = 32'($signed(m3_reg) >>> 11) + 32'd32768;
        gp_next = g1_reg * g2_reg;
        gb_next = 32'($signed(gp_reg) >>> 10) + HUM_BIAS;
        gm_next = gb_reg * h2;
        gc_next = 32'($signed(gm_reg + 32'd8192) >>> 14);
        x2_next = hv7_reg * gc_reg;
        y       = 32'($signed(x2_reg) >>> 15);
        yy_next = y * y;
        zh_next = 32'($signed(yy_reg) >>> 7) * h1;
        x3      = x2c_reg - 32'($signed(zh_reg) >>> 4);
        if ($signed(x3) < 0) begin
            hs = '0;
        end else if ($signed(x3) > HUM_CLAMP_MAX) begin
            hs = HUM_CLAMP_MAX;
        end else begin
            hs = x3;
        end
        hum_next = hs[28:12];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg    <= x_next;
            adc1_reg <= raw_humidity;
            m5_reg   <= m5_next;
            m6_reg   <= m6_next;
            m3_reg   <= m3_next;
            adc2_reg <= adc1_reg;
            hv3_reg  <= hv_next;
            g1_reg   <= g1_next;
            g2_reg   <= g2_next;
            gp_reg   <= gp_next;
            hv4_reg  <= hv3_reg;
            gb_reg   <= gb_next;
            hv5_reg  <= hv4_reg;
            gm_reg   <= gm_next;
            hv6_reg  <= hv5_reg;
            gc_reg   <= gc_next;
            hv7_reg  <= hv6_reg;
            x2_reg   <= x2_next;
            yy_reg   <= yy_next;
            x2b_reg  <= x2_reg;
            zh_reg   <= zh_next;
            x2c_reg  <= x2b_reg;
            hum_reg  <= hum_next;
        end
    end

    assign hum = hum_reg;

endmodule

// ===== hw/rtl/env_sensor_compensation.sv =====
// throughput: one beat per cycle while the result beat is not stalled; the 32-stage divider sets the depth
// a stalled result beat freezes every stage together, nothing is dropped
// reset clears the valid pipeline and all calibration registers to zero
// payload registers are not reset
module env_sensor_compensation (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [19:0]                       s_raw_temperature,
    input  logic [19:0]                       s_raw_pressure,
    input  logic [15:0]                       s_raw_humidity,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [23:0]                m_temperature_centi_c,
    output logic [31:0]                       m_pressure_q24_8,
    output logic                              m_pressure_invalid,
    output logic [16:0]                       m_humidity_q22_10,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [env_comp_pkg::ADDR_W-1:0]   paddr,
    input  logic [env_comp_pkg::DATA_W-1:0]   pwdata,
    output logic [env_comp_pkg::DATA_W-1:0]   prdata,
    output logic                              pready
);
    import env_comp_pkg::*;

    localparam int TEMP_DLY = PIPE_LAT - TEMP_LAT;
    localparam int HUM_DLY  = PIPE_LAT - HUM_LAT;

    cal_t              cal_next, cal_reg;
    logic              en;
    logic [PIPE_LAT-1:0] vld_reg;
    logic [19:0]       rp_dly_reg [0:FINE_LAT-1];
    logic [15:0]       rh_dly_reg [0:FINE_LAT-1];
    logic [23:0]       temp_dly_reg [0:TEMP_DLY-1];
    logic [16:0]       hum_dly_reg [0:HUM_DLY-1];
    logic [31:0]       fine;
    logic [23:0]       temp;
    logic [63:0]       num;
    logic [30:0]       div;
    logic [63:0]       quo;
    logic              div_inv;
    logic [31:0]       press;
    logic              press_inv;
    logic [16:0]       hum;

    // calibration register file
    always_comb begin
        cal_next = cal_reg;
        if (psel && penable && pwrite) begin
            unique case (reg_idx_t'(paddr[5:3]))
                REG_TEMP_CAL:   cal_next.temp       = pwdata[47:0];
                REG_PRESS_LO:   cal_next.press_lo   = pwdata;
                REG_PRESS_HI:   cal_next.press_hi   = pwdata;
                REG_PRESS_LAST: cal_next.press_last = pwdata[15:0];
                REG_HUM_CAL:    cal_next.hum        = pwdata;
                default:        cal_next = cal_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx_t'(paddr[5:3]))
            REG_TEMP_CAL:   prdata = {16'd0, cal_reg.temp};
            REG_PRESS_LO:   prdata = cal_reg.press_lo;
            REG_PRESS_HI:   prdata = cal_reg.press_hi;
            REG_PRESS_LAST: prdata = {48'd0, cal_reg.press_last};
            REG_HUM_CAL:    prdata = cal_reg.hum;
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_reg <= '0;
        end else begin
            cal_reg <= cal_next;
        end
    end

    assign pready = 1'b1;

    // whole pipeline advances together unless the output beat is held
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[PIPE_LAT-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rp_dly_reg[0] <= s_raw_pressure;
            rh_dly_reg[0] <= s_raw_humidity;
            for (int i = 1; i < FINE_LAT; i++) begin
                rp_dly_reg[i] <= rp_dly_reg[i-1];
                rh_dly_reg[i] <= rh_dly_reg[i-1];
            end
            temp_dly_reg[0] <= temp;
            for (int i = 1; i < TEMP_DLY; i++) begin
                temp_dly_reg[i] <= temp_dly_reg[i-1];
            end
            hum_dly_reg[0] <= hum;
            for (int i = 1; i < HUM_DLY; i++) begin
                hum_dly_reg[i] <= hum_dly_reg[i-1];
            end
        end
    end

    env_comp_temp u_temp (
        .aclk            (aclk),
        .en              (en),
        .raw_temperature (s_raw_temperature),
        .cal             (cal_reg),
        .fine            (fine),
        .temp            (temp)
    );

    env_comp_press_pre u_press_pre (
        .aclk         (aclk),
        .en           (en),
        .fine         (fine),
        .raw_pressure (rp_dly_reg[FINE_LAT-1]),
        .cal          (cal_reg),
        .num          (num),
        .div          (div)
    );

    env_comp_div u_div (
        .aclk    (aclk),
        .en      (en),
        .num     (num),
        .div     (div),
        .quo     (quo),
        .invalid (div_inv)
    );

    env_comp_press_post u_press_post (
        .aclk          (aclk),
        .en            (en),
        .quo           (quo),
        .invalid       (div_inv),
        .cal           (cal_reg),
        .press         (press),
        .press_invalid (press_inv)
    );

    env_comp_hum u_hum (
        .aclk         (aclk),
        .en           (en),
        .fine         (fine),
        .raw_humidity (rh_dly_reg[FINE_LAT-1]),
        .cal          (cal_reg),
        .hum          (hum)
    );

    assign m_valid               = vld_reg[PIPE_LAT-1];
    assign m_temperature_centi_c = $signed(temp_dly_reg[TEMP_DLY-1]);
    assign m_pressure_q24_8      = press;
    assign m_pressure_invalid    = press_inv;
    assign m_humidity_q22_10     = hum_dly_reg[HUM_DLY-1];

`ifndef SYNTHESIS
    a_inv_forces_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_pressure_invalid |-> m_pressure_q24_8 == 32'd0)
        else $error("pressure not zero on an invalid divisor");

    a_hum_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_humidity_q22_10 <= HUM_OUT_MAX)
        else $error("humidity above full scale");

    a_beat_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[0])
        else $error("accepted beat missing from first stage");

    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved while output stalled");
`endif

endmodule

// ===== test/env_sensor_compensation_test.sv =====
// testbench for the environmental sensor compensation pipeline
module env_sensor_compensation_test;
    import env_comp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [19:0] raw_t;
        logic [19:0] raw_p;
        logic [15:0] raw_h;
    } sample_t;

    typedef struct {
        logic signed [23:0] temp;
        logic [31:0]        press;
        logic               invalid;
        logic [16:0]        hum;
    } reading_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [19:0] s_raw_temperature = '0;
    logic [19:0] s_raw_pressure = '0;
    logic [15:0] s_raw_humidity = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [23:0] m_temperature_centi_c;
    logic [31:0] m_pressure_q24_8;
    logic m_pressure_invalid;
    logic [16:0] m_humidity_q22_10;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    env_sensor_compensation dut (.*);

    always #1 aclk = ~aclk;

    // calibration copy
    logic [47:0] cal_temp;
    logic [63:0] cal_plo, cal_phi, cal_hum;
    logic [15:0] cal_plast;

    sample_t  pending_samples[$];
    reading_t expected_readings[$];
    int errors = 0;
    int checked = 0;
    int idle_cycles = 0;
    bit calm = 0;       // no idling in the last part
    bit hold_off = 0;   // long receiver stall
    int send_gap = 0;
    int recv_gap = 0;

    function automatic logic [31:0] asr32(logic [31:0] v, int n);
        return $signed(v) >>> n;
    endfunction

    function automatic logic [63:0] asr64(logic [63:0] v, int n);
        return $signed(v) >>> n;
    endfunction

    function automatic reading_t compensate(sample_t s);
        reading_t r;
        logic [31:0] t1, t2, t3, a, b, v1, v2, fine, x, hv, g;
        logic [31:0] h1, h2, h3, h4, h5, h6;
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, w1, w2, p;
        logic [31:0] adc_t;
        logic [63:0] adc_p;
        logic [31:0] adc_h;
        adc_t = {12'd0, s.raw_t};
        adc_p = {44'd0, s.raw_p};
        adc_h = {16'd0, s.raw_h};
        t1 = {16'd0, cal_temp[15:0]};
        t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
        t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
        p1 = {48'd0, cal_plo[15:0]};
        p2 = {{48{cal_plo[31]}}, cal_plo[31:16]};
        p3 = {{48{cal_plo[47]}}, cal_plo[47:32]};
        p4 = {{48{cal_plo[63]}}, cal_plo[63:48]};
        p5 = {{48{cal_phi[15]}}, cal_phi[15:0]};
        p6 = {{48{cal_phi[31]}}, cal_phi[31:16]};
        p7 = {{48{cal_phi[47]}}, cal_phi[47:32]};
        p8 = {{48{cal_phi[63]}}, cal_phi[63:48]};
        p9 = {{48{cal_plast[15]}}, cal_plast};
        h1 = {24'd0, cal_hum[7:0]};
        h2 = {{16{cal_hum[23]}}, cal_hum[23:8]};
        h3 = {24'd0, cal_hum[31:24]};
        h4 = {{20{cal_hum[43]}}, cal_hum[43:32]};
        h5 = {{20{cal_hum[55]}}, cal_hum[55:44]};
        h6 = {{24{cal_hum[63]}}, cal_hum[63:56]};

        a = (adc_t >> 3) - (t1 << 1);
        v1 = asr32(a * t2, 11);
        b = (adc_t >> 4) - t1;
        v2 = asr32(asr32(b * b, 12) * t3, 14);
        fine = v1 + v2;
        r.temp = 24'(asr32(fine * 32'd5 + 32'd128, 8));

        w1 = {{32{fine[31]}}, fine} - 64'd128000;
        w2 = w1 * w1 * p6;
        w2 = w2 + ((w1 * p5) << 17);
        w2 = w2 + (p4 << 35);
        w1 = asr64(w1 * w1 * p3, 8) + ((w1 * p2) << 12);
        w1 = asr64(((64'd1 << 47) + w1) * p1, 33);
        if (w1 == 0) begin
            r.invalid = 1'b1;
            r.press = '0;
        end else begin
            r.invalid = 1'b0;
            p = 64'd1048576 - adc_p;
            p = ((p << 31) - w2) * 64'd3125;
            if (w1 == '1) p = -p;
            else p = $signed(p) / $signed(w1);
            w1 = asr64(p9 * asr64(p, 13) * asr64(p, 13), 25);
            w2 = asr64(p8 * p, 19);
            p = asr64(p + w1 + w2, 8) + (p7 << 4);
            if ($signed(p) < 0) r.press = '0;
            else if ($signed(p) > 64'sh0FFFFFFFF) r.press = '1;
            else r.press = p[31:0];
        end

        x = fine - 32'd76800;
        hv = (adc_h << 14) - (h4 << 20) - h5 * x;
        hv = asr32(hv + 32'd16384, 15);
        g = asr32(x * h6, 10) * (asr32(x * h3, 11) + 32'd32768);
        g = asr32(g, 10) + 32'd2097152;
        g = asr32(g * h2 + 32'd8192, 14);
        x = hv * g;
        x = x - asr32(asr32(asr32(x, 15) * asr32(x, 15), 7) * h1, 4);
        if ($signed(x) < 0) x = 0;
        if ($signed(x) > 419430400) x = 419430400;
        r.hum = 17'(x >> 12);
        return r;
    endfunction

    // sender
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_readings.push_back(compensate('{s_raw_temperature,
                    s_raw_pressure, s_raw_humidity}));
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 9) == 0) begin
                    send_gap <= $urandom_range(1, 17) - 1;
                    s_valid <= 1'b0;
                end else if (pending_samples.size() > 0) begin
                    sample_t s;
                    s = pending_samples.pop_front();
                    s_valid <= 1'b1;
                    s_raw_temperature <= s.raw_t;
                    s_raw_pressure <= s.raw_p;
                    s_raw_humidity <= s.raw_h;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                reading_t e;
                if (expected_readings.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result beat");
                end else begin
                    e = expected_readings.pop_front();
                    checked++;
                    if (e.temp !== m_temperature_centi_c || e.press !== m_pressure_q24_8
                        || e.invalid !== m_pressure_invalid
                        || e.hum !== m_humidity_q22_10) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp t=%0d p=%0h i=%0b h=%0d got t=%0d p=%0h i=%0b h=%0d",
                                e.temp, e.press, e.invalid, e.hum, m_temperature_centi_c,
                                m_pressure_q24_8, m_pressure_invalid, m_humidity_q22_10);
                    end
                end
            end
            if (hold_off) begin
                m_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                recv_gap <= $urandom_range(1, 17) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [63:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(8 * int'(idx));
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_TEMP_CAL:   cal_temp = value[47:0];
            REG_PRESS_LO:   cal_plo = value;
            REG_PRESS_HI:   cal_phi = value;
            REG_PRESS_LAST: cal_plast = value[15:0];
            REG_HUM_CAL:    cal_hum = value;
            default: ;
        endcase
    endtask

    // queues and valid are looked at between edges, once all updates have settled
    task automatic drain;
        while (pending_samples.size() > 0 || s_valid || expected_readings.size() > 0)
            @(negedge aclk);
        repeat (PIPE_LAT + 10) @(posedge aclk);
    endtask

    function automatic sample_t random_sample();
        sample_t s;
        s.raw_t = $urandom;
        s.raw_p = $urandom;
        s.raw_h = $urandom;
        if ($urandom_range(0, 3) != 0) begin
            // typical conversions
            s.raw_t = $urandom_range(400000, 600000);
            s.raw_p = $urandom_range(250000, 450000);
            s.raw_h = $urandom_range(20000, 40000);
        end
        return s;
    endfunction

    task automatic load_calibration(int mode);
        logic [63:0] v [5];
        case (mode)
            0: v = '{64'h0, 64'h0, 64'h0, 64'h0, 64'h0};
            1: v = '{64'hFFFFFFFFFFFF, '1, '1, 64'hFFFF, '1};
            2: v = '{64'h8000_8000_FFFF, 64'h8000_8000_8000_FFFF,
                     64'h8000_8000_8000_8000, 64'h8000, 64'h80_800_800_FF_8000_FF};
            // typical sensor coefficients
            3: v = '{{16'sd50, 16'sd26435, 16'd27504},
                     {16'sd2855, -16'sd10, 16'sd3024, -16'sd10685, 16'd36477},
                     {-16'sd12000, 16'sd15500, -16'sd7, 16'sd140},
                     64'hFFFF & 64'(16'sd4210),
                     {8'd30, 12'd50, 12'd312, 8'd0, 16'sd362, 8'd75}};
            default: v = '{{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                           {$urandom, $urandom}, {$urandom, $urandom}};
        endcase
        write_reg(REG_TEMP_CAL, v[0] & 64'hFFFFFFFFFFFF);
        write_reg(REG_PRESS_LO, v[1]);
        write_reg(REG_PRESS_HI, v[2]);
        write_reg(REG_PRESS_LAST, v[3] & 64'hFFFF);
        write_reg(REG_HUM_CAL, v[4]);
    endtask

    initial begin
        cal_temp = '0; cal_plo = '0; cal_phi = '0; cal_plast = '0; cal_hum = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        // directed extremes under zero calibration (invalid pressure path)
        pending_samples.push_back('{20'h0, 20'h0, 16'h0});
        pending_samples.push_back('{20'hFFFFF, 20'hFFFFF, 16'hFFFF});
        drain();
        for (int mode = 1; mode <= 3; mode++) begin
            load_calibration(mode);
            pending_samples.push_back('{20'h0, 20'h0, 16'h0});
            pending_samples.push_back('{20'hFFFFF, 20'hFFFFF, 16'hFFFF});
            pending_samples.push_back('{20'hAAAAA, 20'h55555, 16'hAAAA});
            pending_samples.push_back('{20'h55555, 20'hAAAAA, 16'h5555});
            pending_samples.push_back('{20'd519888, 20'd415148, 16'd30000});
            drain();
        end
        // long receiver stall while the sender keeps offering
        hold_off = 1;
        repeat (100) pending_samples.push_back(random_sample());
        repeat (300) @(posedge aclk);
        hold_off = 0;
        drain();
        for (int phase = 0; phase < 5; phase++) begin
            load_calibration(phase < 3 ? 3 : 4);
            if (phase == 4) calm = 1;
            repeat (60) pending_samples.push_back(random_sample());
            drain();
        end
        $display("checked %0d result beats over several calibration sets", checked);
        $display("including zero, all-ones, most-negative and typical coefficients");
        if (errors == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end
endmodule
